/* design/ps2s1_pkg.sv */
package ps2s1_pkg;

	localparam logic [7:0] PREFIX_E0 = 8'hE0;
	localparam logic [7:0] PREFIX_E1 = 8'hE1;
	localparam int         BREAK_BIT = 7;

	localparam logic [6:0] SC_LSHIFT = 7'h2A;
	localparam logic [6:0] SC_RSHIFT = 7'h36;
	localparam logic [6:0] SC_CAPS   = 7'h3A;
	localparam logic [6:0] SC_UP     = 7'h48;
	localparam logic [6:0] SC_LEFT   = 7'h4B;
	localparam logic [6:0] SC_RIGHT  = 7'h4D;
	localparam logic [6:0] SC_DOWN   = 7'h50;

	localparam logic [1:0] SHIFT_MAX = 2'd3;
	localparam logic [7:0] CASE_DIFF = 8'h20;

	typedef logic [1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_ARROW_UP    = 2'd0;
	localparam cfg_idx_t CFG_ARROW_LEFT  = 2'd1;
	localparam cfg_idx_t CFG_ARROW_RIGHT = 2'd2;
	localparam cfg_idx_t CFG_ARROW_DOWN  = 2'd3;

	localparam logic [7:0] ARROW_UP_RST    = 8'd128;
	localparam logic [7:0] ARROW_LEFT_RST  = 8'd129;
	localparam logic [7:0] ARROW_RIGHT_RST = 8'd130;
	localparam logic [7:0] ARROW_DOWN_RST  = 8'd131;

	typedef struct packed {
		logic       func;
		logic [7:0] scan_byte;
	} scan_item_t;

	typedef struct packed {
		logic [7:0] read_char;
		logic       read_valid;
		logic       push_dropped;
		logic       char_pushed;
	} result_item_t;

	typedef struct packed {
		logic [7:0] up;
		logic [7:0] left;
		logic [7:0] right;
		logic [7:0] down;
	} arrow_codes_t;

	typedef struct packed {
		logic       push_en;
		logic [7:0] push_char;
		logic       key_we;
		logic       key_set;
		logic [1:0] shift_next;
		logic       caps_next;
		logic       prefix_next;
	} dec_t;

	function automatic logic [7:0] key_char(input logic [6:0] sc);
		logic [7:0] c;
		c = 8'h00;
		unique case (sc)
			7'h01: c = 8'h1B;
			7'h02: c = 8'h31;
			7'h03: c = 8'h32;
			7'h04: c = 8'h33;
			7'h05: c = 8'h34;
			7'h06: c = 8'h35;
			7'h07: c = 8'h36;
			7'h08: c = 8'h37;
			7'h09: c = 8'h38;
			7'h0A: c = 8'h39;
			7'h0B: c = 8'h30;
			7'h0C: c = 8'h2D;
			7'h0D: c = 8'h3D;
			7'h0E: c = 8'h08;
			7'h0F: c = 8'h09;
			7'h10: c = 8'h71;
			7'h11: c = 8'h77;
			7'h12: c = 8'h65;
			7'h13: c = 8'h72;
			7'h14: c = 8'h74;
			7'h15: c = 8'h79;
			7'h16: c = 8'h75;
			7'h17: c = 8'h69;
			7'h18: c = 8'h6F;
			7'h19: c = 8'h70;
			7'h1A: c = 8'h5B;
			7'h1B: c = 8'h5D;
			7'h1C: c = 8'h0A;
			7'h1E: c = 8'h61;
			7'h1F: c = 8'h73;
			7'h20: c = 8'h64;
			7'h21: c = 8'h66;
			7'h22: c = 8'h67;
			7'h23: c = 8'h68;
			7'h24: c = 8'h6A;
			7'h25: c = 8'h6B;
			7'h26: c = 8'h6C;
			7'h27: c = 8'h3B;
			7'h28: c = 8'h27;
			7'h29: c = 8'h60;
			7'h2B: c = 8'h5C;
			7'h2C: c = 8'h7A;
			7'h2D: c = 8'h78;
			7'h2E: c = 8'h63;
			7'h2F: c = 8'h76;
			7'h30: c = 8'h62;
			7'h31: c = 8'h6E;
			7'h32: c = 8'h6D;
			7'h33: c = 8'h2C;
			7'h34: c = 8'h2E;
			7'h35: c = 8'h2F;
			7'h37: c = 8'h2A;
			7'h39: c = 8'h20;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] shifted_digit(input logic [7:0] c);
		logic [7:0] s;
		s = c;
		unique case (c)
			8'h31: s = 8'h21;
			8'h32: s = 8'h40;
			8'h33: s = 8'h23;
			8'h34: s = 8'h24;
			8'h35: s = 8'h25;
			8'h36: s = 8'h5E;
			8'h37: s = 8'h26;
			8'h38: s = 8'h2A;
			8'h39: s = 8'h28;
			8'h30: s = 8'h29;
			default: s = c;
		endcase
		return s;
	endfunction

endpackage

/* design/ps2s1_if.sv */
interface ps2s1_scan_if;
	import ps2s1_pkg::*;

	logic       valid;
	logic       ready;
	scan_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ps2s1_result_if;
	import ps2s1_pkg::*;

	logic         valid;
	logic         ready;
	result_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* design/ps2_set1_scancode_to_ascii_top.sv */
// PS/2 set-1 scancode decoder with a character FIFO. Each transfer on scan is
// either a raw scancode byte (func 0) or a read request (func 1) and gives
// exactly one transfer on result. One transfer is taken every cycle unless
// result stalls: an input register, the decode logic and one FIFO port
// access, then the result register. The FIFO holds FIFO_DEPTH-1 characters in
// a memory with a registered read port; a character decoded while it is full
// is lost and flagged by push_dropped. The user must write arrow codes via
// cfg_we/cfg_idx/cfg_wdata only while the block is idle; it is not enforced.
module ps2_set1_scancode_to_ascii_top #(
	parameter int FIFO_DEPTH = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ps2s1_scan_if.sink           scan,
	ps2s1_result_if.source       result,
	input  logic                 cfg_we,
	input  ps2s1_pkg::cfg_idx_t  cfg_idx,
	input  logic [7:0]           cfg_wdata
);
	import ps2s1_pkg::*;

	scan_item_t   item_s1;
	logic         key_bit_s1;
	logic         valid_s1;
	logic         valid_s2;
	logic         read_valid_s2;
	logic         dropped_s2;
	logic         pushed_s2;
	logic         adv;

	arrow_codes_t arrows_q;
	logic [127:0] keys_q;
	logic [1:0]   shift_q;
	logic         caps_q;
	logic         prefix_q;

	dec_t         dec;
	logic         is_scan;
	logic         push_req;
	logic         pop_req;
	logic         pushed;
	logic         dropped;
	logic         popped;
	logic [7:0]   rdata;

	assign adv        = valid_s1 && (!valid_s2 || result.ready);
	assign scan.ready = !valid_s1 || adv;
	assign is_scan    = !item_s1.func;
	assign push_req   = adv && is_scan && dec.push_en;
	assign pop_req    = adv && item_s1.func;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arrows_q.up    <= ARROW_UP_RST;
			arrows_q.left  <= ARROW_LEFT_RST;
			arrows_q.right <= ARROW_RIGHT_RST;
			arrows_q.down  <= ARROW_DOWN_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_ARROW_UP:    arrows_q.up    <= cfg_wdata;
				CFG_ARROW_LEFT:  arrows_q.left  <= cfg_wdata;
				CFG_ARROW_RIGHT: arrows_q.right <= cfg_wdata;
				CFG_ARROW_DOWN:  arrows_q.down  <= cfg_wdata;
				default:         arrows_q       <= arrows_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (scan.ready)
			valid_s1 <= scan.valid;
	end

	// take the key bit with the item, bypassing the write of the item ahead
	always_ff @(posedge clk) begin
		if (scan.ready && scan.valid) begin
			item_s1 <= scan.data;
			if (adv && is_scan && dec.key_we &&
					(item_s1.scan_byte[6:0] == scan.data.scan_byte[6:0]))
				key_bit_s1 <= dec.key_set;
			else
				key_bit_s1 <= keys_q[scan.data.scan_byte[6:0]];
		end
	end

	ps2s1_decode u_decode (
		.scan_byte      (item_s1.scan_byte),
		.key_bit        (key_bit_s1),
		.shift_count    (shift_q),
		.caps_on        (caps_q),
		.prefix_pending (prefix_q),
		.arrows         (arrows_q),
		.dec            (dec)
	);

	// advance key map and modifier state on each scancode transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_q   <= '0;
			shift_q  <= '0;
			caps_q   <= 1'b0;
			prefix_q <= 1'b0;
		end else if (adv && is_scan) begin
			shift_q  <= dec.shift_next;
			caps_q   <= dec.caps_next;
			prefix_q <= dec.prefix_next;
			if (dec.key_we)
				keys_q[item_s1.scan_byte[6:0]] <= dec.key_set;
		end
	end

	ps2s1_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_req  (push_req),
		.push_data (dec.push_char),
		.pop_req   (pop_req),
		.pushed    (pushed),
		.dropped   (dropped),
		.popped    (popped),
		.rdata     (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= 1'b1;
		else if (result.ready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			read_valid_s2 <= popped;
			dropped_s2    <= dropped;
			pushed_s2     <= pushed;
		end
	end

	assign result.valid             = valid_s2;
	assign result.data.read_char    = read_valid_s2 ? rdata : 8'h00;
	assign result.data.read_valid   = read_valid_s2;
	assign result.data.push_dropped = dropped_s2;
	assign result.data.char_pushed  = pushed_s2;

endmodule

/* design/ps2s1_decode.sv */
module ps2s1_decode (
	input  logic [7:0]              scan_byte,
	input  logic                    key_bit,
	input  logic [1:0]              shift_count,
	input  logic                    caps_on,
	input  logic                    prefix_pending,
	input  ps2s1_pkg::arrow_codes_t arrows,
	output ps2s1_pkg::dec_t         dec
);
	import ps2s1_pkg::*;

	logic       brk;
	logic [6:0] sc;
	logic       is_shift;
	logic       is_arrow;
	logic [7:0] arrow_char;
	logic [7:0] base_char;
	logic       shifted;
	logic       is_letter;
	logic [7:0] cooked_char;

	assign brk      = scan_byte[BREAK_BIT];
	assign sc       = scan_byte[6:0];
	assign is_shift = (sc == SC_LSHIFT) || (sc == SC_RSHIFT);
	assign shifted  = (shift_count != 2'd0);

	always_comb begin
		is_arrow   = 1'b1;
		arrow_char = arrows.up;
		unique case (sc)
			SC_UP:    arrow_char = arrows.up;
			SC_LEFT:  arrow_char = arrows.left;
			SC_RIGHT: arrow_char = arrows.right;
			SC_DOWN:  arrow_char = arrows.down;
			default:  is_arrow   = 1'b0;
		endcase
	end

	assign base_char = key_char(sc);
	assign is_letter = (base_char >= 8'h61) && (base_char <= 8'h7A);

	always_comb begin
		cooked_char = base_char;
		if (is_letter) begin
			if (shifted != caps_on)
				cooked_char = base_char - CASE_DIFF;
		end else if (shifted) begin
			cooked_char = shifted_digit(base_char);
		end
	end

	always_comb begin
		dec.push_en     = 1'b0;
		dec.push_char   = cooked_char;
		dec.key_we      = 1'b0;
		dec.key_set     = 1'b0;
		dec.shift_next  = shift_count;
		dec.caps_next   = caps_on;
		dec.prefix_next = 1'b0;
		if ((scan_byte == PREFIX_E0) || (scan_byte == PREFIX_E1)) begin
			dec.prefix_next = 1'b1;
		end else if (prefix_pending) begin
			dec.push_char = arrow_char;
			dec.push_en   = !is_shift && !brk && is_arrow;
		end else if (brk) begin
			dec.key_we = 1'b1;
			if (is_shift && shifted)
				dec.shift_next = shift_count - 2'd1;
		end else begin
			dec.key_we  = 1'b1;
			dec.key_set = 1'b1;
			if (is_shift) begin
				if (!key_bit && (shift_count != SHIFT_MAX))
					dec.shift_next = shift_count + 2'd1;
			end else if (sc == SC_CAPS) begin
				if (!key_bit)
					dec.caps_next = !caps_on;
			end else if (is_arrow) begin
				dec.push_char = arrow_char;
				dec.push_en   = 1'b1;
			end else begin
				dec.push_en = (base_char != 8'h00);
			end
		end
	end

endmodule

/* design/ps2s1_fifo.sv */
module ps2s1_fifo #(
	parameter int DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_req,
	input  logic [7:0] push_data,
	input  logic       pop_req,
	output logic       pushed,
	output logic       dropped,
	output logic       popped,
	output logic [7:0] rdata
);
	localparam int PW = $clog2(DEPTH);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	logic [7:0]    mem [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [PW-1:0] wnext;
	logic [PW-1:0] rnext;
	logic          full;
	logic          empty;

	assign wnext   = (wptr_q == LAST) ? '0 : wptr_q + PW'(1);
	assign rnext   = (rptr_q == LAST) ? '0 : rptr_q + PW'(1);
	assign full    = (wnext == rptr_q);
	assign empty   = (wptr_q == rptr_q);
	assign pushed  = push_req && !full;
	assign dropped = push_req && full;
	assign popped  = pop_req && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			if (pushed)
				wptr_q <= wnext;
			if (popped)
				rptr_q <= rnext;
		end
	end

	always_ff @(posedge clk) begin
		if (pushed)
			mem[wptr_q] <= push_data;
	end

	always_ff @(posedge clk) begin
		if (popped)
			rdata <= mem[rptr_q];
	end

endmodule

/* sim/ps2_set1_scancode_to_ascii_top_tb.sv */
module ps2_set1_scancode_to_ascii_top_tb;
	import ps2s1_pkg::*;

	localparam int DEPTH       = 256;
	localparam int LATENCY     = 8;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;

	localparam logic FUNC_SCAN = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	localparam logic [7:0] KEYMAP [0:57] = '{
		8'h00, 8'd27, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0",
		"-", "=", 8'd8, 8'd9, "q", "w", "e", "r", "t", "y", "u", "i",
		"o", "p", "[", "]", 8'd10, 8'h00, "a", "s", "d", "f", "g",
		"h", "j", "k", "l", ";", "'", 8'h60, 8'h00, "\\", "z", "x",
		"c", "v", "b", "n", "m", ",", ".", "/", 8'h00, "*", 8'h00, " "
	};
	localparam logic [7:0] DIGIT_SYMS [0:8] = '{"!", "@", "#", "$", "%", "^", "&", "*", "("};

	localparam logic [8:0] DIRECTED [0:25] = '{
		{FUNC_READ, 8'h00},
		{FUNC_SCAN, 8'h01},
		{FUNC_SCAN, 8'h1E},
		{FUNC_SCAN, 1'b0, SC_CAPS},
		{FUNC_SCAN, 1'b0, SC_CAPS},
		{FUNC_SCAN, 8'h1E},
		{FUNC_SCAN, 1'b1, SC_CAPS},
		{FUNC_SCAN, 1'b0, SC_LSHIFT},
		{FUNC_SCAN, 1'b0, SC_LSHIFT},
		{FUNC_SCAN, 8'h02},
		{FUNC_SCAN, 8'h0B},
		{FUNC_SCAN, 8'h1E},
		{FUNC_SCAN, 1'b1, SC_LSHIFT},
		{FUNC_SCAN, 1'b1, SC_RSHIFT},
		{FUNC_SCAN, PREFIX_E0},
		{FUNC_SCAN, 1'b0, SC_UP},
		{FUNC_SCAN, PREFIX_E0},
		{FUNC_SCAN, PREFIX_E1},
		{FUNC_SCAN, 1'b0, SC_LSHIFT},
		{FUNC_SCAN, PREFIX_E1},
		{FUNC_SCAN, 1'b1, SC_DOWN},
		{FUNC_SCAN, 1'b0, SC_LEFT},
		{FUNC_SCAN, 8'h00},
		{FUNC_SCAN, 8'h7F},
		{FUNC_SCAN, 8'hFF},
		{FUNC_READ, 8'hFF}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	cfg_idx_t   cfg_idx = CFG_ARROW_UP;
	logic [7:0] cfg_wdata = 8'h00;

	ps2s1_scan_if   scan_ch ();
	ps2s1_result_if result_ch ();

	ps2_set1_scancode_to_ascii_top #(.FIFO_DEPTH(DEPTH)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.scan     (scan_ch),
		.result   (result_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// decoder state as the block should hold it
	logic [127:0] held_keys = '0;
	logic [1:0]   shifts_down = '0;
	logic         caps_active = 1'b0;
	logic         prefix_seen = 1'b0;
	logic [7:0]   char_ring [0:DEPTH-1];
	int           ring_wr = 0;
	int           ring_rd = 0;
	arrow_codes_t arrows = '{ARROW_UP_RST, ARROW_LEFT_RST, ARROW_RIGHT_RST, ARROW_DOWN_RST};

	scan_item_t   scan_backlog [$];
	result_item_t results_due [$];

	int   errors = 0;
	int   stall_cycles = 0;
	int   send_idle_pct = 24;
	int   recv_idle_pct = 78;
	int   recv_hold_left = 0;
	logic long_hold_req = 1'b0;
	logic long_hold_done = 1'b0;
	logic scan_took = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [8:0] arrow_lookup(input logic [6:0] sc);
		logic [8:0] hit;
		hit = '0;
		if (sc == SC_UP)
			hit = {1'b1, arrows.up};
		else if (sc == SC_LEFT)
			hit = {1'b1, arrows.left};
		else if (sc == SC_RIGHT)
			hit = {1'b1, arrows.right};
		else if (sc == SC_DOWN)
			hit = {1'b1, arrows.down};
		return hit;
	endfunction

	function automatic result_item_t decode_scan(input scan_item_t it);
		result_item_t res;
		logic         brk;
		logic         is_shift;
		logic         rep;
		logic         has_push;
		logic [6:0]   sc;
		logic [7:0]   c;
		logic [8:0]   arr;
		int           nxt;
		res = '0;
		has_push = 1'b0;
		c = 8'h00;
		if (it.func == FUNC_READ) begin
			if (ring_rd != ring_wr) begin
				res.read_char = char_ring[ring_rd];
				res.read_valid = 1'b1;
				ring_rd = (ring_rd + 1) % DEPTH;
			end
			return res;
		end
		if (it.scan_byte == PREFIX_E0 || it.scan_byte == PREFIX_E1) begin
			prefix_seen = 1'b1;
			return res;
		end
		brk = it.scan_byte[BREAK_BIT];
		sc = it.scan_byte[6:0];
		is_shift = (sc == SC_LSHIFT) || (sc == SC_RSHIFT);
		arr = arrow_lookup(sc);
		if (prefix_seen) begin
			prefix_seen = 1'b0;
			if (!is_shift && !brk && arr[8]) begin
				has_push = 1'b1;
				c = arr[7:0];
			end
		end else if (brk) begin
			held_keys[sc] = 1'b0;
			if (is_shift && shifts_down != 2'd0)
				shifts_down = shifts_down - 2'd1;
		end else begin
			rep = held_keys[sc];
			held_keys[sc] = 1'b1;
			if (is_shift) begin
				if (!rep && shifts_down != SHIFT_MAX)
					shifts_down = shifts_down + 2'd1;
			end else if (sc == SC_CAPS) begin
				if (!rep)
					caps_active = !caps_active;
			end else if (arr[8]) begin
				has_push = 1'b1;
				c = arr[7:0];
			end else begin
				c = (sc < 7'd58) ? KEYMAP[sc] : 8'h00;
				if (c != 8'h00) begin
					has_push = 1'b1;
					if (c >= "a" && c <= "z") begin
						if ((shifts_down != 2'd0) != caps_active)
							c = c - CASE_DIFF;
					end else if (shifts_down != 2'd0) begin
						if (c >= "1" && c <= "9")
							c = DIGIT_SYMS[c - "1"];
						else if (c == "0")
							c = ")";
					end
				end
			end
		end
		if (has_push) begin
			nxt = (ring_wr + 1) % DEPTH;
			if (nxt == ring_rd) begin
				res.push_dropped = 1'b1;
			end else begin
				char_ring[ring_wr] = c;
				ring_wr = nxt;
				res.char_pushed = 1'b1;
			end
		end
		return res;
	endfunction

	// sender
	always @(negedge clk) begin
		if (!arst_n) begin
			scan_ch.valid <= 1'b0;
		end else if (!scan_ch.valid || scan_took) begin
			if (scan_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				scan_ch.data <= scan_backlog.pop_front();
				scan_ch.valid <= 1'b1;
			end else begin
				scan_ch.valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (recv_hold_left > 0) begin
			recv_hold_left <= recv_hold_left - 1;
			result_ch.ready <= 1'b0;
		end else if (long_hold_req && !long_hold_done) begin
			recv_hold_left <= HOLD_CYCLES;
			long_hold_done <= 1'b1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// predict on input transfer, check on result transfer
	always @(posedge clk) begin
		if (arst_n) begin
			scan_took <= scan_ch.valid && scan_ch.ready;
			if (scan_ch.valid && scan_ch.ready)
				results_due.push_back(decode_scan(scan_ch.data));
			if (result_ch.valid && result_ch.ready) begin
				if (results_due.size() == 0) begin
					errors++;
					$display("%0t unexpected result: expected none, got %h", $time,
						result_ch.data);
				end else begin
					result_item_t want;
					want = results_due.pop_front();
					if (result_ch.data.read_char !== want.read_char) begin
						errors++;
						$display("%0t read_char: expected %h, got %h", $time,
							want.read_char, result_ch.data.read_char);
					end
					if (result_ch.data.read_valid !== want.read_valid) begin
						errors++;
						$display("%0t read_valid: expected %b, got %b", $time,
							want.read_valid, result_ch.data.read_valid);
					end
					if (result_ch.data.push_dropped !== want.push_dropped) begin
						errors++;
						$display("%0t push_dropped: expected %b, got %b", $time,
							want.push_dropped, result_ch.data.push_dropped);
					end
					if (result_ch.data.char_pushed !== want.char_pushed) begin
						errors++;
						$display("%0t char_pushed: expected %b, got %b", $time,
							want.char_pushed, result_ch.data.char_pushed);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((scan_ch.valid && scan_ch.ready) || (result_ch.valid && result_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic add_scan(input logic [7:0] b);
		scan_backlog.push_back('{func: FUNC_SCAN, scan_byte: b});
	endtask

	task automatic add_read();
		scan_backlog.push_back('{func: FUNC_READ, scan_byte: 8'($urandom)});
	endtask

	task automatic add_traffic(input int n, input int read_pct);
		int         start;
		int         r;
		logic [6:0] sc;
		start = scan_backlog.size();
		while (scan_backlog.size() - start < n) begin
			r = $urandom_range(0, 99);
			if (r < read_pct) begin
				repeat ($urandom_range(1, 3)) add_read();
			end else if (r < read_pct + 8) begin
				add_scan(8'($urandom));
			end else if (r < read_pct + 16) begin
				sc = $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT;
				add_scan({1'($urandom_range(0, 1)), sc});
			end else if (r < read_pct + 20) begin
				add_scan({1'b0, SC_CAPS});
				add_scan({1'b1, SC_CAPS});
			end else if (r < read_pct + 32) begin
				add_scan($urandom_range(0, 1) ? PREFIX_E0 : PREFIX_E1);
				if ($urandom_range(0, 9) == 0)
					add_scan($urandom_range(0, 1) ? PREFIX_E0 : PREFIX_E1);
				case ($urandom_range(0, 5))
					0: sc = SC_LSHIFT;
					1: sc = SC_RSHIFT;
					2: sc = SC_UP;
					3: sc = SC_LEFT;
					4: sc = SC_RIGHT;
					default: sc = 7'($urandom);
				endcase
				add_scan({1'($urandom_range(0, 3) == 0), sc});
			end else begin
				sc = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 57));
				add_scan({1'b0, sc});
				if ($urandom_range(0, 2) == 0)
					add_scan({1'b0, sc});
				if ($urandom_range(0, 3) != 0)
					add_scan({1'b1, sc});
			end
		end
	endtask

	task automatic settle();
		while (scan_backlog.size() != 0 || scan_ch.valid || results_due.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_ARROW_UP:    arrows.up = val;
			CFG_ARROW_LEFT:  arrows.left = val;
			CFG_ARROW_RIGHT: arrows.right = val;
			default:         arrows.down = val;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		scan_ch.valid = 1'b0;
		scan_ch.data = '0;
		result_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 24;
		recv_idle_pct = 78;
		foreach (DIRECTED[i])
			scan_backlog.push_back(scan_item_t'(DIRECTED[i]));
		add_traffic(150, 20);
		settle();

		write_reg(CFG_ARROW_UP, 8'h00);
		write_reg(CFG_ARROW_LEFT, 8'hFF);
		write_reg(CFG_ARROW_RIGHT, 8'hFF);
		write_reg(CFG_ARROW_DOWN, 8'h00);

		// hold the receiver and overfill the ring
		send_idle_pct = 78;
		recv_idle_pct = 24;
		long_hold_req = 1'b1;
		repeat (300) begin
			if ($urandom_range(0, 9) == 0) begin
				add_scan($urandom_range(0, 1) ? PREFIX_E0 : PREFIX_E1);
				add_scan({1'b0, $urandom_range(0, 1) ? SC_UP : SC_DOWN});
			end else begin
				add_scan(8'($urandom_range(8'h10, 8'h19)));
			end
		end
		repeat (300) add_read();
		add_traffic(100, 20);
		settle();

		write_reg(CFG_ARROW_UP, 8'($urandom));
		write_reg(CFG_ARROW_LEFT, 8'($urandom));
		write_reg(CFG_ARROW_RIGHT, 8'($urandom));
		write_reg(CFG_ARROW_DOWN, 8'($urandom));

		send_idle_pct = 0;
		recv_idle_pct = 0;
		add_traffic(150, 25);
		settle();

		if (results_due.size() != 0)
			errors++;
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
